[rtl/rsc_pkg.sv]
// Shared types and constants for the radix string converter.
// Depends on nothing; every other file imports it.
`default_nettype none

package rsc_pkg;

   localparam int VALUE_W     = 64;  // accumulated value, wraps modulo 2^64
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;   // digit values 0..15
   localparam int BASE_W      = 5;   // base registers hold 0..31
   localparam int ALPHA_SLOTS = 16;
   localparam int DIV_BITS    = 4;   // quotient bits produced per divide cycle
   localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int REG_IDX_W   = 3;

   localparam logic [REG_IDX_W-1:0] REG_SRC_LO  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SRC_HI  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SRC_B   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TGT_LO  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TGT_HI  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_TGT_B   = 3'd5;

   typedef enum logic [0:0] {
      ALU_MAC,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_READ,
      ST_LOAD,
      ST_ERROR
   } state_type;

   // Alphabets and effective (clamped) bases as seen by the datapath
   typedef struct packed {
      logic [VALUE_W-1:0] src_lo;
      logic [VALUE_W-1:0] src_hi;
      logic [BASE_W-1:0]  src_base;
      logic [VALUE_W-1:0] tgt_lo;
      logic [VALUE_W-1:0] tgt_hi;
      logic [BASE_W-1:0]  tgt_base;
   } cfg_type;

   function automatic logic [CHAR_W-1:0] symbol_at(input logic [VALUE_W-1:0] lo,
                                                   input logic [VALUE_W-1:0] hi,
                                                   input logic [DIGIT_W-1:0] k);
      logic [VALUE_W-1:0] word;
      word = k[DIGIT_W-1] ? hi : lo;
      return word[k[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
   endfunction

endpackage

`default_nettype wire

[rtl/rsc_req_if.sv]
// Input character channel: valid/ready handshake with character and last flag.
// Depends on rsc_pkg.
`default_nettype none

interface rsc_req_if import rsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   logic              in_last;

   modport source (output valid, in_char, in_last, input ready);
   modport sink   (input valid, in_char, in_last, output ready);
endinterface

`default_nettype wire

[rtl/rsc_rsp_if.sv]
// Result character channel: valid/ready handshake with character, last and error flag.
// Depends on rsc_pkg.
`default_nettype none

interface rsc_rsp_if import rsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              out_last;
   logic              bad_symbol;

   modport source (output valid, out_char, out_last, bad_symbol, input ready);
   modport sink   (input valid, out_char, out_last, bad_symbol, output ready);
endinterface

`default_nettype wire

[rtl/rsc_csr.sv]
// APB-style configuration registers: alphabets and bases, with base clamping.
// Depends on rsc_pkg.
`default_nettype none

module rsc_csr import rsc_pkg::*; #(
   parameter int MAX_BASE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   localparam int BASE_CAP = (MAX_BASE < ALPHA_SLOTS) ? MAX_BASE : ALPHA_SLOTS;

   logic [VALUE_W-1:0] src_lo_ff, src_hi_ff, tgt_lo_ff, tgt_hi_ff;
   logic [BASE_W-1:0]  src_base_ff, tgt_base_ff;
   logic [REG_IDX_W-1:0] idx;
   logic               wr_en;

   function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] raw);
      logic [BASE_W-1:0] b;
      b = raw;
      if (b < BASE_W'(2)) b = BASE_W'(2);
      if (b > BASE_W'(BASE_CAP)) b = BASE_W'(BASE_CAP);
      return b;
   endfunction

   assign csr_pready = 1'b1;
   assign idx   = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_lo_ff   <= '0;
         src_hi_ff   <= '0;
         src_base_ff <= BASE_W'(2);
         tgt_lo_ff   <= '0;
         tgt_hi_ff   <= '0;
         tgt_base_ff <= BASE_W'(2);
      end else if (wr_en) begin
         case (idx)
            REG_SRC_LO: src_lo_ff   <= csr_pwdata;
            REG_SRC_HI: src_hi_ff   <= csr_pwdata;
            REG_SRC_B:  src_base_ff <= csr_pwdata[BASE_W-1:0];
            REG_TGT_LO: tgt_lo_ff   <= csr_pwdata;
            REG_TGT_HI: tgt_hi_ff   <= csr_pwdata;
            REG_TGT_B:  tgt_base_ff <= csr_pwdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SRC_LO: csr_prdata = src_lo_ff;
         REG_SRC_HI: csr_prdata = src_hi_ff;
         REG_SRC_B:  csr_prdata = CSR_DATA_W'(src_base_ff);
         REG_TGT_LO: csr_prdata = tgt_lo_ff;
         REG_TGT_HI: csr_prdata = tgt_hi_ff;
         REG_TGT_B:  csr_prdata = CSR_DATA_W'(tgt_base_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.src_lo   = src_lo_ff;
      cfg.src_hi   = src_hi_ff;
      cfg.src_base = eff_base(src_base_ff);
      cfg.tgt_lo   = tgt_lo_ff;
      cfg.tgt_hi   = tgt_hi_ff;
      cfg.tgt_base = eff_base(tgt_base_ff);
   end

endmodule

`default_nettype wire

[rtl/rsc_alu.sv]
// Shared arithmetic unit: multiply-accumulate by the source base, or a
// four-bit restoring divide step by the target base. Depends on rsc_pkg.
`default_nettype none

module rsc_alu import rsc_pkg::*; (
   input  wire alu_op_type           op,
   input  wire logic [VALUE_W-1:0]   operand,
   input  wire logic [DIGIT_W-1:0]   rem_in,
   input  wire logic [BASE_W-1:0]    base,
   input  wire logic [DIGIT_W-1:0]   digit,
   output      logic [VALUE_W-1:0]   result,
   output      logic [DIGIT_W-1:0]   rem_out
);

   logic [VALUE_W-1:0] sh;
   logic [DIGIT_W:0]   part;
   logic [DIGIT_W-1:0] r;

   always_comb begin
      sh   = operand;
      r    = rem_in;
      part = '0;
      case (op)
         ALU_MAC: begin
            result  = operand * VALUE_W'(base) + VALUE_W'(digit);
            rem_out = rem_in;
         end
         ALU_DIV: begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            for (int i = 0; i < DIV_BITS; i++) begin
               part = {r, sh[VALUE_W-1]};
               sh   = {sh[VALUE_W-2:0], 1'b0};
               if (part >= base) begin
                  part  = part - base;
                  sh[0] = 1'b1;
               end
               r = part[DIGIT_W-1:0];
            end
            result  = sh;
            rem_out = r;
         end
         default: begin
            result  = operand;
            rem_out = rem_in;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/rsc_digit_ram.sv]
// Digit buffer: one write port, one registered read port.
// Depends on rsc_pkg.
`default_nettype none

module rsc_digit_ram import rsc_pkg::*; #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               we,
   input  wire logic [ADDR_W-1:0]  waddr,
   input  wire logic [DIGIT_W-1:0] wdata,
   input  wire logic               re,
   input  wire logic [ADDR_W-1:0]  raddr,
   output      logic [DIGIT_W-1:0] rdata
);

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/radix_string_converter.sv]
// Radix string converter. Source characters arrive one per transaction, most
// significant first, and are mapped to digits by the configured source alphabet;
// the value builds up as value*source_base+digit modulo 2^64. A transaction with
// in_last set starts conversion: the value is divided by the target base in a
// shared restoring divider that yields 4 quotient bits per cycle, and the target
// digits then leave most significant first, each through a digit buffer read and
// then the output register. A character outside the alphabet makes the number
// yield one result with bad_symbol set. Configuration uses an APB-style port
// with 64-bit registers at 8-byte spacing. Depends on rsc_pkg, the channel
// interfaces, rsc_csr, rsc_alu and rsc_digit_ram.
`default_nettype none

module radix_string_converter import rsc_pkg::*; #(
   parameter int MAX_BASE   = 16,
   parameter int MAX_DIGITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rsc_req_if.sink                    req_chan,
   rsc_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

   cfg_type cfg;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               err_ff, err_in;
   logic               found_ff, found_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               last_ff, last_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic               bad_ff, bad_in;

   alu_op_type         alu_op;
   logic [VALUE_W-1:0] alu_result;
   logic [DIGIT_W-1:0] alu_rem;
   logic               ram_we, ram_re;
   logic [DIGIT_W-1:0] ram_rdata;
   logic               lookup_found;
   logic [DIGIT_W-1:0] lookup_digit;
   logic               slot_free;
   logic               err_next;

   rsc_csr #(.MAX_BASE(MAX_BASE)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rsc_alu u_alu (
      .op      (alu_op),
      .operand (acc_ff),
      .rem_in  (rem_ff),
      .base    ((alu_op == ALU_MAC) ? cfg.src_base : cfg.tgt_base),
      .digit   (digit_ff),
      .result  (alu_result),
      .rem_out (alu_rem)
   );

   rsc_digit_ram #(.DEPTH(MAX_DIGITS), .ADDR_W(ADDR_W)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (alu_rem),
      .re    (ram_re),
      .raddr (count_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   // First match in the source alphabet, limited to the effective base
   always_comb begin
      lookup_found = 1'b0;
      lookup_digit = '0;
      for (int k = ALPHA_SLOTS - 1; k >= 0; k--) begin
         if (BASE_W'(k) < cfg.src_base &&
             symbol_at(cfg.src_lo, cfg.src_hi, DIGIT_W'(k)) == req_chan.in_char) begin
            lookup_found = 1'b1;
            lookup_digit = DIGIT_W'(k);
         end
      end
   end

   assign slot_free         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_char = out_char_ff;
   assign rsp_chan.out_last = out_last_ff;
   assign rsp_chan.bad_symbol = bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      digit_ff    <= digit_in;
      last_ff     <= last_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      bad_ff      <= bad_in;
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      found_in     = found_ff;
      digit_in     = digit_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      bad_in       = bad_ff;
      alu_op       = ALU_MAC;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      err_next     = err_ff | !found_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               found_in = lookup_found;
               digit_in = lookup_digit;
               last_in  = req_chan.in_last;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (found_ff) acc_in = alu_result;
            err_in = err_next;
            if (last_ff) begin
               if (err_next) begin
                  acc_in   = '0;
                  state_in = ST_ERROR;
               end else begin
                  rem_in   = '0;
                  step_in  = '0;
                  count_in = '0;
                  state_in = ST_DIV;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            alu_op  = ALU_DIV;
            acc_in  = alu_result;
            rem_in  = alu_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               // remainder is the next target digit, least significant first
               ram_we = 1'b1;
               rem_in = '0;
               if (alu_result != '0 && count_ff != CNT_W'(MAX_DIGITS - 1)) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  acc_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_char_in  = symbol_at(cfg.tgt_lo, cfg.tgt_hi, ram_rdata);
               out_last_in  = (count_ff == '0);
               bad_in       = 1'b0;
               if (count_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_char_in  = '0;
               out_last_in  = 1'b1;
               bad_in       = 1'b1;
               err_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && bad_ff |-> out_last_ff && out_char_ff == '0)
      else $error("error result not marked last or carries a character");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count beyond buffer depth");

   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < DIGIT_W'(0) + cfg.tgt_base)
      else $error("partial remainder not below target base");

   a_idle_after_number: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD && slot_free && count_ff == '0 |=> acc_ff == '0 && !err_ff)
      else $error("number state not cleared after conversion");

endmodule

`default_nettype wire
